/* src/big_pkg.sv */
`default_nettype none
package big_pkg;

  // defaults for the top-level parameters
  localparam int MAX_DIMS_DEF   = 4;
  localparam int DIM_BITS_DEF   = 16;
  localparam int INDEX_BITS_DEF = 32;

  // fixed port widths
  localparam int FIELD_BITS     = 32;
  localparam int SHAPE_BITS     = 64;
  localparam int RANK_BITS      = 3;
  localparam int REG_INDEX_BITS = 3;
  localparam int QUEUE_DEPTH    = 2;

  // register map
  localparam logic [REG_INDEX_BITS-1:0] REG_FIRST_RANK   = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_SECOND_RANK  = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_FIRST_SHAPE  = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_SECOND_SHAPE = 3'd3;

  localparam logic [RANK_BITS-1:0]  RANK_RESET  = 3'd1;
  localparam logic [SHAPE_BITS-1:0] SHAPE_RESET = 64'h0001_0001_0001_0001;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SHAPE = 2'd1,
    ST_BEYOND    = 2'd2
  } status_t;

endpackage
`default_nettype wire

/* src/big_if.sv */
`default_nettype none
interface big_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [big_pkg::REG_INDEX_BITS-1:0]   index;
  logic [big_pkg::SHAPE_BITS-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface big_req_if;
  logic                             valid;
  logic                             ready;
  logic [big_pkg::FIELD_BITS-1:0]   result_index;
  modport source (output valid, output result_index, input ready);
  modport sink   (input valid, input result_index, output ready);
endinterface

interface big_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [big_pkg::FIELD_BITS-1:0]   first_index;
  logic [big_pkg::FIELD_BITS-1:0]   second_index;
  logic [1:0]                       status;
  modport source (output valid, output first_index, output second_index, output status,
                  input ready);
  modport sink   (input valid, input first_index, input second_index, input status,
                  output ready);
endinterface
`default_nettype wire

/* src/big_front.sv */
`default_nettype none
module big_front #(
  parameter int MAX_DIMS   = big_pkg::MAX_DIMS_DEF,
  parameter int DIM_BITS   = big_pkg::DIM_BITS_DEF,
  parameter int INDEX_BITS = big_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  big_cfg_if.sink               cfg,
  big_req_if.sink               req,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [INDEX_BITS+1:0] q_data,
  output logic [DIM_BITS-1:0]   dr [MAX_DIMS],
  output logic [MAX_DIMS-1:0]   a_one,
  output logic [MAX_DIMS-1:0]   b_one,
  output logic [INDEX_BITS-1:0] sa [MAX_DIMS],
  output logic [INDEX_BITS-1:0] sb [MAX_DIMS]
);

  localparam int PAD_BITS = big_pkg::SHAPE_BITS + MAX_DIMS * DIM_BITS;

  logic [big_pkg::RANK_BITS-1:0]  first_rank;
  logic [big_pkg::RANK_BITS-1:0]  second_rank;
  logic [big_pkg::SHAPE_BITS-1:0] first_shape;
  logic [big_pkg::SHAPE_BITS-1:0] second_shape;

  logic [PAD_BITS-1:0]   pad_a, pad_b;
  logic [DIM_BITS-1:0]   da [MAX_DIMS];
  logic [DIM_BITS-1:0]   db [MAX_DIMS];
  logic [MAX_DIMS-1:0]   bad_dim, empty_dim;
  logic [INDEX_BITS-1:0] sa_r [MAX_DIMS];
  logic [INDEX_BITS-1:0] sb_r [MAX_DIMS];
  big_pkg::status_t      cls;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_rank   <= big_pkg::RANK_RESET;
      second_rank  <= big_pkg::RANK_RESET;
      first_shape  <= big_pkg::SHAPE_RESET;
      second_shape <= big_pkg::SHAPE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        big_pkg::REG_FIRST_RANK:   first_rank   <= cfg.data[big_pkg::RANK_BITS-1:0];
        big_pkg::REG_SECOND_RANK:  second_rank  <= cfg.data[big_pkg::RANK_BITS-1:0];
        big_pkg::REG_FIRST_SHAPE:  first_shape  <= cfg.data;
        big_pkg::REG_SECOND_SHAPE: second_shape <= cfg.data;
        default: ;
      endcase
    end
  end

  // fields above the register read as size 0
  assign pad_a = PAD_BITS'(first_shape);
  assign pad_b = PAD_BITS'(second_shape);

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
    logic in_a, in_b;
    // rank 0 counts as 1, so the innermost dimension is always present
    assign in_a  = (k == 0) || (int'(first_rank) > k);
    assign in_b  = (k == 0) || (int'(second_rank) > k);
    assign da[k] = in_a ? pad_a[k*DIM_BITS +: DIM_BITS] : DIM_BITS'(1);
    assign db[k] = in_b ? pad_b[k*DIM_BITS +: DIM_BITS] : DIM_BITS'(1);
    assign a_one[k] = (da[k] == DIM_BITS'(1));
    assign b_one[k] = (db[k] == DIM_BITS'(1));
    assign dr[k]    = a_one[k] ? db[k] : da[k];
    assign bad_dim[k]   = (da[k] != db[k]) && !a_one[k] && !b_one[k];
    assign empty_dim[k] = (dr[k] == '0);
  end

  // operand strides settle one dimension per cycle after a write
  always_ff @(posedge clk) begin
    sa_r[0] <= INDEX_BITS'(1);
    sb_r[0] <= INDEX_BITS'(1);
    for (int k = 1; k < MAX_DIMS; k++) begin
      sa_r[k] <= INDEX_BITS'(sa_r[k-1] * da[k-1]);
      sb_r[k] <= INDEX_BITS'(sb_r[k-1] * db[k-1]);
    end
  end

  assign sa = sa_r;
  assign sb = sb_r;

  always_comb begin
    priority if (|bad_dim) cls = big_pkg::ST_BAD_SHAPE;
    else if (|empty_dim)   cls = big_pkg::ST_BEYOND;
    else                   cls = big_pkg::ST_OK;
  end

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;
  assign q_data    = {cls, INDEX_BITS'(req.result_index)};

endmodule
`default_nettype wire

/* src/big_fifo.sv */
`default_nettype none
module big_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = big_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push, do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end
  end

endmodule
`default_nettype wire

/* src/big_back.sv */
`default_nettype none
module big_back #(
  parameter int MAX_DIMS   = big_pkg::MAX_DIMS_DEF,
  parameter int DIM_BITS   = big_pkg::DIM_BITS_DEF,
  parameter int INDEX_BITS = big_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  logic [INDEX_BITS+1:0] q_data,
  output logic                  q_pop,
  input  logic [DIM_BITS-1:0]   dr [MAX_DIMS],
  input  logic [MAX_DIMS-1:0]   a_one,
  input  logic [MAX_DIMS-1:0]   b_one,
  input  logic [INDEX_BITS-1:0] sa [MAX_DIMS],
  input  logic [INDEX_BITS-1:0] sb [MAX_DIMS],
  big_rsp_if.source             rsp
);

  localparam int NS   = MAX_DIMS * INDEX_BITS;
  localparam int LAST = MAX_DIMS - 1;

  logic [NS:0]           v;
  logic [INDEX_BITS-1:0] n  [NS+1];
  logic [DIM_BITS-1:0]   r  [NS+1];
  logic [INDEX_BITS-1:0] ia [NS+1];
  logic [INDEX_BITS-1:0] ib [NS+1];
  big_pkg::status_t      st [NS+1];

  logic                  adv;
  logic                  out_v;
  logic [INDEX_BITS-1:0] out_ia, out_ib;
  big_pkg::status_t      out_st;
  logic [INDEX_BITS-1:0] ia_f, ib_f;
  big_pkg::status_t      st_f;

  // whole pipe moves together; holds while the output word waits
  assign adv   = !out_v || rsp.ready;
  assign q_pop = adv && !q_empty;

  assign v[0]  = !q_empty;
  assign n[0]  = q_data[INDEX_BITS-1:0];
  assign st[0] = big_pkg::status_t'(q_data[INDEX_BITS+1:INDEX_BITS]);
  assign r[0]  = '0;
  assign ia[0] = '0;
  assign ib[0] = '0;

  // one restoring division bit per stage, INDEX_BITS stages per dimension
  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int K = s / INDEX_BITS;
    localparam int J = s % INDEX_BITS;
    logic [DIM_BITS-1:0]   r_in;
    logic [INDEX_BITS-1:0] ia_in, ib_in;
    logic [DIM_BITS:0]     sh;
    logic                  ge;

    if (J == 0) begin : g_head
      assign r_in = '0;
      if (K == 0) begin : g_none
        assign ia_in = ia[s];
        assign ib_in = ib[s];
      end else begin : g_acc
        // remainder of the previous dimension is its coordinate
        assign ia_in = ia[s] + (a_one[K-1] ? INDEX_BITS'(0)
                                           : INDEX_BITS'(r[s] * sa[K-1]));
        assign ib_in = ib[s] + (b_one[K-1] ? INDEX_BITS'(0)
                                           : INDEX_BITS'(r[s] * sb[K-1]));
      end
    end else begin : g_body
      assign r_in  = r[s];
      assign ia_in = ia[s];
      assign ib_in = ib[s];
    end

    assign sh = {r_in, n[s][INDEX_BITS-1]};
    assign ge = (sh >= {1'b0, dr[K]});

    always_ff @(posedge clk) begin
      if (adv) begin
        n[s+1]  <= {n[s][INDEX_BITS-2:0], ge};
        r[s+1]  <= ge ? DIM_BITS'(sh - {1'b0, dr[K]}) : sh[DIM_BITS-1:0];
        ia[s+1] <= ia_in;
        ib[s+1] <= ib_in;
        st[s+1] <= st[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
    end
  end

  assign ia_f = ia[NS] + (a_one[LAST] ? INDEX_BITS'(0) : INDEX_BITS'(r[NS] * sa[LAST]));
  assign ib_f = ib[NS] + (b_one[LAST] ? INDEX_BITS'(0) : INDEX_BITS'(r[NS] * sb[LAST]));

  // leftover quotient means the position lies past the result
  always_comb begin
    priority if (st[NS] != big_pkg::ST_OK) st_f = st[NS];
    else if (n[NS] != '0)                  st_f = big_pkg::ST_BEYOND;
    else                                   st_f = big_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_st <= st_f;
      out_ia <= (st_f == big_pkg::ST_OK) ? ia_f : '0;
      out_ib <= (st_f == big_pkg::ST_OK) ? ib_f : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= v[NS];
    end
  end

  assign rsp.valid        = out_v;
  assign rsp.first_index  = big_pkg::FIELD_BITS'(out_ia);
  assign rsp.second_index = big_pkg::FIELD_BITS'(out_ib);
  assign rsp.status       = out_st;

endmodule
`default_nettype wire

/* src/broadcast_index_generator.sv */
// Path from accepted word to result: the queue, the divider stages, then the output register.
// Throughput: one word per cycle while the response side is ready; the divider pipeline takes one bit a stage.
// Reset (rst, synchronous): ranks 1, all sizes 1, queue and pipe emptied.
// Operand strides are registered and settle one dimension at a time, in order, after a rank or shape write.
`default_nettype none
module broadcast_index_generator #(
  parameter int MAX_DIMS   = big_pkg::MAX_DIMS_DEF,
  parameter int DIM_BITS   = big_pkg::DIM_BITS_DEF,
  parameter int INDEX_BITS = big_pkg::INDEX_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  big_cfg_if.sink   cfg,
  big_req_if.sink   req,
  big_rsp_if.source rsp
);

  // queue word: status from the front, then the reduced position
  localparam int QW = INDEX_BITS + 2;

  logic                  q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]         q_wdata, q_rdata;
  logic [DIM_BITS-1:0]   dr [MAX_DIMS];
  logic [MAX_DIMS-1:0]   a_one, b_one;
  logic [INDEX_BITS-1:0] sa [MAX_DIMS];
  logic [INDEX_BITS-1:0] sb [MAX_DIMS];

  // front: config registers, per-dimension sizes, shape check per word
  big_front #(
    .MAX_DIMS   (MAX_DIMS),
    .DIM_BITS   (DIM_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata),
    .dr     (dr),
    .a_one  (a_one),
    .b_one  (b_one),
    .sa     (sa),
    .sb     (sb)
  );

  // short queue lets the front keep accepting while the back stalls
  big_fifo #(
    .WIDTH (QW),
    .DEPTH (big_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // back: mixed-radix split by bit-serial division, stride multiply-accumulate
  big_back #(
    .MAX_DIMS   (MAX_DIMS),
    .DIM_BITS   (DIM_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .dr      (dr),
    .a_one   (a_one),
    .b_one   (b_one),
    .sa      (sa),
    .sb      (sb),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire

/* dv/big_checker.sv */
`default_nettype none
module big_checker (
  input  logic        clk,
  input  logic        rst,
  big_cfg_if.sink     cfg,
  big_req_if.sink     req,
  big_rsp_if.sink     rsp,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [big_pkg::FIELD_BITS-1:0] first_index;
    logic [big_pkg::FIELD_BITS-1:0] second_index;
    big_pkg::status_t               status;
  } mapping_t;

  logic [big_pkg::RANK_BITS-1:0]  rank_a, rank_b;
  logic [big_pkg::SHAPE_BITS-1:0] shape_a, shape_b;
  mapping_t                       mapping_q[$];
  int                             fails = 0;

  function automatic int eff_rank(logic [big_pkg::RANK_BITS-1:0] r);
    if (r < 1) return 1;
    if (r > big_pkg::MAX_DIMS_DEF) return big_pkg::MAX_DIMS_DEF;
    return int'(r);
  endfunction

  function automatic longint unsigned size_of(logic [big_pkg::SHAPE_BITS-1:0] s, int r,
                                              int k);
    if (k >= r) return 64'd1;
    if (k * big_pkg::DIM_BITS_DEF >= big_pkg::SHAPE_BITS) return 64'd0;
    return (s >> (k * big_pkg::DIM_BITS_DEF)) & ((64'd1 << big_pkg::DIM_BITS_DEF) - 64'd1);
  endfunction

  function automatic mapping_t map_index(logic [big_pkg::FIELD_BITS-1:0] pos);
    mapping_t m;
    int ra, rb, rr;
    bit bad, empty;
    longint unsigned da, db, dr, rem, c, ia, ib, sa, sb;
    ra = eff_rank(rank_a);
    rb = eff_rank(rank_b);
    rr = (ra > rb) ? ra : rb;
    bad = 0; empty = 0;
    m = '0;
    m.status = big_pkg::ST_OK;
    for (int k = 0; k < rr; k++) begin
      da = size_of(shape_a, ra, k);
      db = size_of(shape_b, rb, k);
      dr = (da == 1) ? db : da;
      if (da != db && da != 1 && db != 1) bad = 1;
      if (dr == 0) empty = 1;
    end
    if (bad) begin
      m.status = big_pkg::ST_BAD_SHAPE;
      return m;
    end
    if (empty) begin
      m.status = big_pkg::ST_BEYOND;
      return m;
    end
    rem = 64'(pos); ia = '0; ib = '0; sa = 64'd1; sb = 64'd1;
    for (int k = 0; k < rr; k++) begin
      da = size_of(shape_a, ra, k);
      db = size_of(shape_b, rb, k);
      dr = (da == 1) ? db : da;
      c = rem % dr;
      rem = rem / dr;
      if (da != 1) ia += c * sa;
      if (db != 1) ib += c * sb;
      sa *= da;
      sb *= db;
    end
    if (rem != 0) begin
      m.status = big_pkg::ST_BEYOND;
      return m;
    end
    m.first_index = ia[31:0];
    m.second_index = ib[31:0];
    return m;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  assign pending    = mapping_q.size();
  assign fail_count = fails;

  always @(posedge clk) begin
    mapping_t w;
    if (rst) begin
      rank_a <= big_pkg::RANK_RESET; rank_b <= big_pkg::RANK_RESET;
      shape_a <= big_pkg::SHAPE_RESET; shape_b <= big_pkg::SHAPE_RESET;
      mapping_q.delete();
    end else begin
      if (req.valid && req.ready) mapping_q.push_back(map_index(req.result_index));
      if (rsp.valid && rsp.ready) begin
        if (mapping_q.size() == 0) begin
          report("unexpected word", 64'd0, 64'd0);
        end else begin
          w = mapping_q.pop_front();
          if (rsp.first_index !== w.first_index)
            report("first_index", 64'(rsp.first_index), 64'(w.first_index));
          if (rsp.second_index !== w.second_index)
            report("second_index", 64'(rsp.second_index), 64'(w.second_index));
          if (rsp.status !== w.status) report("status", 64'(rsp.status), 64'(w.status));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          big_pkg::REG_FIRST_RANK:   rank_a <= cfg.data[big_pkg::RANK_BITS-1:0];
          big_pkg::REG_SECOND_RANK:  rank_b <= cfg.data[big_pkg::RANK_BITS-1:0];
          big_pkg::REG_FIRST_SHAPE:  shape_a <= cfg.data;
          big_pkg::REG_SECOND_SHAPE: shape_b <= cfg.data;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending;
  bit   calm;      // last part: no idling
  int   gap_left;  // sink stall burst

  big_cfg_if cfg_if();
  big_req_if req_if();
  big_rsp_if rsp_if();

  broadcast_index_generator u_top (.clk(clk), .rst(rst), .cfg(cfg_if.sink),
                                   .req(req_if.sink), .rsp(rsp_if.source));
  big_checker u_chk (.clk(clk), .rst(rst), .cfg(cfg_if.sink), .req(req_if.sink),
                     .rsp(rsp_if.sink), .fail_count(fail_count), .pending(pending));

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    cfg_if.valid = 0; cfg_if.index = '0; cfg_if.data = '0;
    req_if.valid = 0; req_if.result_index = '0;
    rsp_if.ready = 0;
  end

  // sink side: random stall bursts, always ready once calm
  always @(posedge clk) begin
    if (rst || calm) begin
      rsp_if.ready <= 1;
      gap_left <= 0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      rsp_if.ready <= 0;
    end else if ($urandom_range(0, 9) == 0) begin
      gap_left <= $urandom_range(1, 19) - 1;
      rsp_if.ready <= 0;
    end else begin
      rsp_if.ready <= 1;
    end
  end

  // valid stays up after the write; the caller drops it
  task automatic write_reg(logic [big_pkg::REG_INDEX_BITS-1:0] idx,
                           logic [big_pkg::SHAPE_BITS-1:0] val);
    cfg_if.valid <= 1; cfg_if.index <= idx; cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // block must be drained before registers move; strides settle a few cycles later
  task automatic drain();
    req_if.valid <= 0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (big_pkg::MAX_DIMS_DEF + 4) @(posedge clk);
  endtask

  task automatic set_shapes(int ra, int rb, logic [63:0] sa, logic [63:0] sb);
    drain();
    write_reg(big_pkg::REG_FIRST_RANK, 64'(ra));
    write_reg(big_pkg::REG_SECOND_RANK, 64'(rb));
    write_reg(big_pkg::REG_FIRST_SHAPE, sa);
    write_reg(big_pkg::REG_SECOND_SHAPE, sb);
    cfg_if.valid <= 0;
    repeat (big_pkg::MAX_DIMS_DEF + 2) @(posedge clk);
  endtask

  // valid stays up between back-to-back words; dropped only for idling
  task automatic send(logic [31:0] pos);
    if (!calm && $urandom_range(0, 7) == 0) begin
      req_if.valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_if.valid <= 1; req_if.result_index <= pos;
    do @(posedge clk); while (!req_if.ready);
  endtask

  function automatic logic [15:0] rnd_size();
    case ($urandom_range(0, 9))
      0: return 16'd1;
      1: return 16'd0;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(1, 7));
    endcase
  endfunction

  function automatic logic [63:0] rnd_shape();
    return {rnd_size(), rnd_size(), rnd_size(), rnd_size()};
  endfunction

  initial begin
    logic [63:0] sa, sb;
    int total;
    calm = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // reset shapes: scalar result, index 0 ok, anything else beyond
    send(0); send(1); send(32'hFFFF_FFFF);
    // plain broadcast 2x3 against 3
    set_shapes(2, 1, 64'h0000_0000_0002_0003, 64'h0001_0001_0001_0003);
    for (int i = 0; i < 7; i++) send(i);
    // incompatible sizes
    set_shapes(1, 1, 64'h3, 64'h4);
    send(0); send(32'hFFFF_FFFF);
    // empty result, rank zero and rank above the limit
    set_shapes(0, 7, 64'h0, 64'h0001_0001_0001_0001);
    send(0); send(5);
    // widest sizes: product wraps the index range
    set_shapes(4, 4, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_0001_FFFF_0001);
    send(0); send(32'hFFFF_FFFF); send(32'h8000_0000); send(32'h1234_5678);
    set_shapes(3, 2, 64'h0000_0005_0001_0004, 64'h0001_0001_0003_0001);
    for (int i = 0; i < 4; i++) send($urandom_range(0, 70));
    total = 0;
    while (total < 850) begin
      sa = rnd_shape(); sb = rnd_shape();
      // mostly compatible pairs: copy dims of one, put ones elsewhere
      if ($urandom_range(0, 3) != 0)
        for (int k = 0; k < 4; k++)
          if ($urandom_range(0, 1)) sb[k*16 +: 16] = sa[k*16 +: 16];
          else if ($urandom_range(0, 1)) sb[k*16 +: 16] = 16'd1;
          else sa[k*16 +: 16] = 16'd1;
      set_shapes(int'($urandom_range(0, 7)), int'($urandom_range(0, 7)), sa, sb);
      if (total > 700) calm = 1;
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(0, 3))
          0: send($urandom());
          1: send($urandom_range(0, 300));
          default: send($urandom_range(0, 4000));
        endcase
        total++;
      end
    end
    drain();
    if (fail_count == 0) $display("broadcast_index_generator test passed");
    else $display("broadcast_index_generator test failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("broadcast_index_generator test failed");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
src/big_pkg.sv
src/big_if.sv
src/big_front.sv
src/big_fifo.sv
src/big_back.sv
src/broadcast_index_generator.sv
dv/big_checker.sv
dv/tb.sv
